FILE: hdl/rsrd_pkg.sv
`default_nettype none
package rsrd_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int CHANNELS  = 4;
   localparam int CFG_WIDTH = 16;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_ROW   = 3'd1,
      ST_HDR   = 3'd2,
      ST_WIDTH = 3'd3,
      ST_ZERO  = 3'd4,
      ST_OVER  = 3'd5,
      ST_PHASE = 3'd6
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } operation_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   // One byte of each plane at one column.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] expo;
   } pixel_bytes_type;

   typedef struct packed {
      logic       en;
      logic [1:0] chan;
      logic [7:0] data;
   } store_write_type;

   // Exact float32 of m * 2^(e-136); zero when m or e is zero.
   function automatic logic [31:0] rgbe_to_float(input logic [7:0] m, input logic [7:0] e);
      logic [2:0]  p;
      logic signed [9:0] biased;
      logic [31:0] mv;
      logic [31:0] res;
      p = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (m[i]) p = 3'(i);
      end
      biased = $signed({7'd0, p}) + $signed({2'd0, e}) - 10'sd9;
      mv = {24'd0, m};
      if (m == 8'd0 || e == 8'd0) begin
         res = 32'd0;
      end else if (biased <= 10'sd0) begin
         res = mv << (5'(e) + 5'd13);
      end else begin
         res = {biased[8:0], 23'd0} | ((mv << (5'd23 - 5'(p))) & 32'h007F_FFFF);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/rsrd_store.sv
`default_nettype none
module rsrd_store #(
   parameter int MAX_WIDTH = rsrd_pkg::MAX_WIDTH,
   parameter int AW = $clog2(MAX_WIDTH)
) (
   input  wire logic                      clock,
   input  wire rsrd_pkg::store_write_type wr,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output rsrd_pkg::pixel_bytes_type      rd_data
);

   logic [7:0] rdata_ff [rsrd_pkg::CHANNELS];

   for (genvar c = 0; c < rsrd_pkg::CHANNELS; c++) begin : g_plane
      logic [7:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (wr.en && wr.chan == 2'(c)) mem[wr_addr] <= wr.data;
         if (rd_en) rdata_ff[c] <= mem[rd_addr];
      end
   end

   assign rd_data = '{red: rdata_ff[0], green: rdata_ff[1], blue: rdata_ff[2],
                      expo: rdata_ff[3]};

endmodule
`default_nettype wire

FILE: hdl/rgbe_scanline_rle_decoder.sv
`default_nettype none
// RGBE scanline run-length decoder.
// Input channel (req_*): each item is either a push of one coded byte
// (req_operation = 0) or a pull of the next decoded pixel (req_operation = 1).
// Result channel (rsp_*): exactly one item per input item, in order, carrying
// the three float32 channel values, row/image end flags and a status code.
// Configuration (csr_*): image width and height, written while idle.
// The store is read into the read stage when an input item is accepted, and
// the float conversion loads the output register from the read stage, from
// which the result is offered.
// Throughput: one item per cycle for header, count, literal and pull items
// while the receiver takes results. A run value byte writes its first byte
// when accepted and then holds req_ready low while the single store write
// port fills the rest of the run; that write port sets the rate.
// Reset clears parsing state, row counter and sticky error; the store keeps
// its contents, and only fully decoded rows are ever read back.
// When the receiver stalls, the output register and the read stage hold,
// and req_ready falls once both are full; no item is lost or repeated.
// Errors (status 2..6) are sticky until reset.
module rgbe_scanline_rle_decoder #(
   parameter int MAX_WIDTH = rsrd_pkg::MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_operation,
   input  wire logic [7:0]                    req_coded_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [31:0]                        rsp_red_bits,
   output logic [31:0]                        rsp_green_bits,
   output logic [31:0]                        rsp_blue_bits,
   output logic                               rsp_last_in_row,
   output logic                               rsp_last_in_image,
   output logic [2:0]                         rsp_status,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [rsrd_pkg::CFG_WIDTH-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   typedef enum logic [2:0] {
      PH_H0, PH_H1, PH_H2, PH_H3, PH_COUNT, PH_RUN, PH_LIT, PH_DRAIN
   } phase_type;

   // Configuration.
   logic [12:0] image_width_ff;
   logic [15:0] image_height_ff;

   // Parser state.
   phase_type  phase_ff, phase_in;
   logic [6:0] hdr_high_ff, hdr_high_in;
   logic [1:0] chan_ff, chan_in;
   logic [CW-1:0] col_ff, col_in;
   logic [7:0] lit_ff, lit_in;
   logic [6:0] run_len_ff, run_len_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic [15:0] row_ff, row_in;
   logic [2:0] sticky_ff, sticky_in;

   // Run fill engine.
   logic [6:0] run_left_ff, run_left_in;
   logic [AW-1:0] run_addr_ff, run_addr_in;
   logic [7:0] run_val_ff, run_val_in;
   logic [1:0] run_chan_ff, run_chan_in;

   // Read stage and output register.
   logic       a_valid_ff;
   logic       a_pix_ff;
   logic [2:0] a_status_ff;
   logic       a_lrow_ff, a_limg_ff;
   logic [2:0] status_in;
   logic       lrow_in, limg_in, pix_in;

   logic busy, accept, a_move;
   rsrd_pkg::store_write_type wr;
   logic [AW-1:0] wr_addr;
   rsrd_pkg::pixel_bytes_type rd_data;

   assign busy   = run_left_ff != 7'd0;
   assign a_move = a_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = (!a_valid_ff || a_move) && !busy;
   assign accept = req_valid && req_ready;

   always_comb begin
      logic [15:0] w_hdr, cw16, n16, sum16, width16;
      logic [7:0]  n;
      logic [CW-1:0] col_adv;
      logic do_adv;

      phase_in    = phase_ff;
      hdr_high_in = hdr_high_ff;
      chan_in     = chan_ff;
      col_in      = col_ff;
      lit_in      = lit_ff;
      run_len_in  = run_len_ff;
      drain_in    = drain_ff;
      row_in      = row_ff;
      sticky_in   = sticky_ff;
      run_left_in = run_left_ff;
      run_addr_in = run_addr_ff;
      run_val_in  = run_val_ff;
      run_chan_in = run_chan_ff;
      status_in   = rsrd_pkg::ST_OK;
      lrow_in     = 1'b0;
      limg_in     = 1'b0;
      pix_in      = 1'b0;
      do_adv      = 1'b0;
      col_adv     = col_ff;
      wr          = '{en: 1'b0, chan: run_chan_ff, data: run_val_ff};
      wr_addr     = run_addr_ff;

      width16 = {3'd0, image_width_ff};
      cw16    = 16'(col_ff);
      w_hdr   = {1'b0, hdr_high_ff, req_coded_byte};
      n       = (req_coded_byte > 8'd128) ? req_coded_byte - 8'd128 : req_coded_byte;
      n16     = {8'd0, n};
      sum16   = cw16 + n16;

      // Drain remaining run bytes, one per cycle.
      if (busy) begin
         wr.en       = 1'b1;
         run_left_in = run_left_ff - 7'd1;
         run_addr_in = run_addr_ff + AW'(1);
      end

      if (accept) begin
         if (sticky_ff != rsrd_pkg::ST_OK) begin
            status_in = sticky_ff;
         end else if (req_operation == rsrd_pkg::OP_PUSH) begin
            case (phase_ff)
               PH_H0, PH_H1: begin
                  if (req_coded_byte != 8'd2) status_in = rsrd_pkg::ST_HDR;
                  else phase_in = (phase_ff == PH_H0) ? PH_H1 : PH_H2;
               end
               PH_H2: begin
                  if (req_coded_byte[7]) status_in = rsrd_pkg::ST_HDR;
                  else begin
                     hdr_high_in = req_coded_byte[6:0];
                     phase_in    = PH_H3;
                  end
               end
               PH_H3: begin
                  if (image_width_ff == 13'd0 || width16 > 16'(MAX_WIDTH)
                      || w_hdr != width16) begin
                     status_in = rsrd_pkg::ST_WIDTH;
                  end else begin
                     chan_in  = 2'd0;
                     col_in   = '0;
                     phase_in = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  if (req_coded_byte == 8'd0) status_in = rsrd_pkg::ST_ZERO;
                  else if (sum16 > width16) status_in = rsrd_pkg::ST_OVER;
                  else if (req_coded_byte > 8'd128) begin
                     run_len_in = n[6:0];
                     phase_in   = PH_RUN;
                  end else begin
                     lit_in   = n;
                     phase_in = PH_LIT;
                  end
               end
               PH_RUN: begin
                  // Write the first byte now; the fill engine does the rest.
                  wr          = '{en: 1'b1, chan: chan_ff, data: req_coded_byte};
                  wr_addr     = col_ff[AW-1:0];
                  run_left_in = run_len_ff - 7'd1;
                  run_addr_in = col_ff[AW-1:0] + AW'(1);
                  run_val_in  = req_coded_byte;
                  run_chan_in = chan_ff;
                  col_adv     = CW'(cw16 + {9'd0, run_len_ff});
                  run_len_in  = 7'd0;
                  do_adv      = 1'b1;
               end
               PH_LIT: begin
                  wr      = '{en: 1'b1, chan: chan_ff, data: req_coded_byte};
                  wr_addr = col_ff[AW-1:0];
                  col_adv = col_ff + CW'(1);
                  col_in  = col_adv;
                  lit_in  = lit_ff - 8'd1;
                  if (lit_ff == 8'd1) do_adv = 1'b1;
               end
               default: status_in = rsrd_pkg::ST_PHASE;
            endcase
            if (do_adv) begin
               col_in = col_adv;
               if (16'(col_adv) < width16) begin
                  phase_in = PH_COUNT;
               end else begin
                  col_in = '0;
                  if (chan_ff == 2'(rsrd_pkg::CHANNELS - 1)) begin
                     chan_in   = 2'd0;
                     drain_in  = '0;
                     phase_in  = PH_DRAIN;
                     status_in = rsrd_pkg::ST_ROW;
                  end else begin
                     chan_in  = chan_ff + 2'd1;
                     phase_in = PH_COUNT;
                  end
               end
            end
            if (status_in >= rsrd_pkg::ST_HDR) sticky_in = status_in;
         end else if (phase_ff != PH_DRAIN) begin
            status_in = rsrd_pkg::ST_PHASE;
            sticky_in = rsrd_pkg::ST_PHASE;
         end else begin
            pix_in  = 1'b1;
            lrow_in = (16'(drain_ff) + 16'd1) >= width16;
            limg_in = lrow_in && (row_ff == image_height_ff - 16'd1);
            if (lrow_in) begin
               drain_in = '0;
               phase_in = PH_H0;
               row_in   = limg_in ? 16'd0 : row_ff + 16'd1;
            end else begin
               drain_in = drain_ff + CW'(1);
            end
         end
      end
   end

   rsrd_store #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (accept && pix_in),
      .rd_addr (drain_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 13'd1;
         image_height_ff <= 16'd1;
         phase_ff        <= PH_H0;
         hdr_high_ff     <= 7'd0;
         chan_ff         <= 2'd0;
         col_ff          <= '0;
         lit_ff          <= 8'd0;
         run_len_ff      <= 7'd0;
         drain_ff        <= '0;
         row_ff          <= 16'd0;
         sticky_ff       <= rsrd_pkg::ST_OK;
         run_left_ff     <= 7'd0;
         a_valid_ff      <= 1'b0;
         rsp_valid       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == rsrd_pkg::CSR_WIDTH) image_width_ff <= csr_wdata[12:0];
            else image_height_ff <= csr_wdata;
         end
         phase_ff    <= phase_in;
         hdr_high_ff <= hdr_high_in;
         chan_ff     <= chan_in;
         col_ff      <= col_in;
         lit_ff      <= lit_in;
         run_len_ff  <= run_len_in;
         drain_ff    <= drain_in;
         row_ff      <= row_in;
         sticky_ff   <= sticky_in;
         run_left_ff <= run_left_in;
         // Advance the read stage and output register.
         if (accept) a_valid_ff <= 1'b1;
         else if (a_move) a_valid_ff <= 1'b0;
         if (a_move) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_addr_ff <= run_addr_in;
      run_val_ff  <= run_val_in;
      run_chan_ff <= run_chan_in;
      if (accept) begin
         a_pix_ff    <= pix_in;
         a_status_ff <= status_in;
         a_lrow_ff   <= lrow_in;
         a_limg_ff   <= limg_in;
      end
      if (a_move) begin
         rsp_red_bits      <= a_pix_ff ? rsrd_pkg::rgbe_to_float(rd_data.red, rd_data.expo)
                                       : 32'd0;
         rsp_green_bits    <= a_pix_ff ? rsrd_pkg::rgbe_to_float(rd_data.green, rd_data.expo)
                                       : 32'd0;
         rsp_blue_bits     <= a_pix_ff ? rsrd_pkg::rgbe_to_float(rd_data.blue, rd_data.expo)
                                       : 32'd0;
         rsp_last_in_row   <= a_lrow_ff;
         rsp_last_in_image <= a_limg_ff;
         rsp_status        <= a_status_ff;
      end
   end

   // Hold input off while the run fill engine owns the write port.
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready) else $error("item taken during run fill");

   // Sticky error never changes until reset.
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (sticky_ff != rsrd_pkg::ST_OK) |=> (sticky_ff == $past(sticky_ff)))
      else $error("sticky error changed");

   // Results with a non-OK status carry a zero red value and no row-end flag.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rsrd_pkg::ST_OK) |->
         (rsp_red_bits == 32'd0 && rsp_last_in_row == 1'b0))
      else $error("payload on non-pixel result");

endmodule
`default_nettype wire
